// ===== sv/bbac_pkg.sv =====
package bbac_pkg;

  localparam int POS_BITS  = 24;
  localparam int DW        = POS_BITS + 1;   // divider operand width
  localparam int LW        = POS_BITS + 2;   // doubled lateral width
  localparam int Q_BITS    = 16;             // normalized ratio, Q16
  localparam int DIV_STEPS = Q_BITS;
  localparam int Q_DEPTH   = 4;
  localparam int Q_AW      = $clog2(Q_DEPTH);
  localparam int ADDR_W    = 5;

  typedef enum logic [2:0] {
    REG_HALF_WIDTH  = 3'd0,
    REG_SOFT_BUFFER = 3'd1,
    REG_RECT_RANGE  = 3'd2,
    REG_AREA_RANGE  = 3'd3,
    REG_PEAK_COST   = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    KIND_NONE    = 2'd0,
    KIND_PEAK    = 2'd1,
    KIND_ELLIPSE = 2'd2
  } kind_t;

  typedef struct packed {
    logic [10:0] half_width;
    logic [10:0] soft_buffer;
    logic [14:0] rect_range;
    logic [14:0] area_range;
    logic [15:0] peak_cost;
  } cfg_t;

  // classified item handed from front to back
  typedef struct packed {
    kind_t         kind;
    logic [14:0]   ads;
    logic [14:0]   aspan;
    logic [DW-1:0] ldist;
    logic [DW-1:0] limit;
  } q_item_t;

  // one restoring division step: {quotient bit, new remainder}
  function automatic logic [DW:0] div_step(input logic [DW-1:0] r,
                                           input logic [DW-1:0] d);
    logic [DW:0] t;
    t = {r, 1'b0};
    if (t >= {1'b0, d}) begin
      div_step = {1'b1, DW'(t - {1'b0, d})};
    end else begin
      div_step = {1'b0, t[DW-1:0]};
    end
  endfunction

endpackage

// ===== sv/bbac_front.sv =====
module bbac_front import bbac_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  cfg_t                       cfg,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [POS_BITS-1:0] box_min_s,
  input  logic signed [POS_BITS-1:0] box_max_s,
  input  logic signed [POS_BITS-1:0] box_min_l,
  input  logic signed [POS_BITS-1:0] box_max_l,
  input  logic signed [POS_BITS-1:0] front_s,
  input  logic signed [POS_BITS-1:0] front_l,
  input  logic signed [POS_BITS-1:0] rear_s,
  input  logic signed [POS_BITS-1:0] rear_l,
  input  logic                       q_full,
  output logic                       q_push,
  output q_item_t                    q_item
);

  logic adv;
  logic f1_valid, f2_valid;
  logic signed [POS_BITS:0] d_f, d_b;
  logic signed [LW-1:0] e_f, e_b, lim;
  q_item_t item;

  logic signed [POS_BITS:0] area_s, sd_full;
  logic f_app, b_app;
  logic signed [LW-1:0] e_sel;
  logic [LW-1:0] ld;
  logic [14:0] sd;
  logic signed [15:0] sdiff, span;
  logic [14:0] ads, aspan;
  logic lim_pos, ld_lt, rect_hit;
  logic [11:0] margin;
  q_item_t item_next;

  assign adv      = !(f2_valid && q_full);
  assign in_ready = adv;
  assign q_push   = f2_valid && !q_full;
  assign q_item   = item;
  assign margin   = 12'({1'b0, cfg.half_width} + {1'b0, cfg.soft_buffer});

  // stage 1: differences
  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
    end else if (adv) begin
      f1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_f <= (POS_BITS+1)'(box_min_s) - (POS_BITS+1)'(front_s);
      d_b <= (POS_BITS+1)'(rear_s) - (POS_BITS+1)'(box_max_s);
      e_f <= (LW'(front_l) <<< 1) - (LW'(box_max_l) + LW'(box_min_l));
      e_b <= (LW'(rear_l) <<< 1) - (LW'(box_max_l) + LW'(box_min_l));
      lim <= LW'(box_max_l) - LW'(box_min_l) + $signed(LW'({margin, 1'b0}));
    end
  end

  // stage 2: pick the deciding point, classify
  always_comb begin
    area_s   = $signed((POS_BITS+1)'(cfg.area_range));
    f_app    = (d_f > 0) && (d_f < area_s);
    b_app    = (d_b > 0) && (d_b < area_s);
    sd_full  = b_app ? d_b : d_f;
    sd       = sd_full[14:0];
    e_sel    = b_app ? e_b : e_f;
    ld       = (e_sel < 0) ? LW'(-e_sel) : LW'(e_sel);
    sdiff    = $signed({1'b0, sd}) - $signed({1'b0, cfg.rect_range});
    ads      = (sdiff < 0) ? 15'(-sdiff) : 15'(sdiff);
    span     = $signed({1'b0, cfg.area_range}) - $signed({1'b0, cfg.rect_range});
    aspan    = (span < 0) ? 15'(-span) : 15'(span);
    lim_pos  = lim > 0;
    ld_lt    = ld < $unsigned(lim);
    rect_hit = (sd < cfg.rect_range) && ld_lt;

    item_next.ads   = ads;
    item_next.aspan = aspan;
    item_next.ldist = ld[DW-1:0];
    item_next.limit = lim[DW-1:0];
    if (!(f_app || b_app) || !lim_pos) begin
      item_next.kind = KIND_NONE;
    end else if (rect_hit) begin
      item_next.kind = KIND_PEAK;
    end else if (span == 0 || ads >= aspan || !ld_lt) begin
      item_next.kind = KIND_NONE;
    end else begin
      item_next.kind = KIND_ELLIPSE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f2_valid <= 1'b0;
    end else if (adv) begin
      f2_valid <= f1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      item <= item_next;
    end
  end

endmodule

// ===== sv/bbac_queue.sv =====
module bbac_queue import bbac_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  q_item_t push_item,
  output logic    full,
  input  logic    pop,
  output logic    empty,
  output q_item_t pop_item
);

  q_item_t mem [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr, rd_ptr;
  logic [Q_AW:0]   count;

  assign full     = count == (Q_AW+1)'(Q_DEPTH);
  assign empty    = count == '0;
  assign pop_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + (Q_AW+1)'(push) - (Q_AW+1)'(pop);
    end
  end

endmodule

// ===== sv/bbac_back.sv =====
module bbac_back import bbac_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [15:0] peak_cost,
  input  logic        q_empty,
  input  q_item_t     q_item,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] obs_cost,
  output logic        cost_set
);

  logic adv;

  // divider stages, both ratios side by side
  logic [DIV_STEPS-1:0] dv;
  kind_t         dk [DIV_STEPS];
  logic [DW-1:0] rs [DIV_STEPS];
  logic [DW-1:0] rl [DIV_STEPS];
  logic [DW-1:0] ds [DIV_STEPS];
  logic [DW-1:0] dl [DIV_STEPS];
  logic [Q_BITS-1:0] qs [DIV_STEPS];
  logic [Q_BITS-1:0] ql [DIV_STEPS];

  logic m_valid, a_valid, p_valid;
  kind_t m_kind, a_kind, p_kind;
  logic [2*Q_BITS-1:0] sq_s, sq_l;
  logic a_in, p_in;
  logic [2*Q_BITS:0] w;
  logic [2*Q_BITS+16:0] prod;
  logic [2*Q_BITS:0] f_sum;

  assign adv   = !out_valid || out_ready;
  assign q_pop = adv && !q_empty;
  assign f_sum = {1'b0, sq_s} + {1'b0, sq_l};

  always_ff @(posedge clk) begin
    if (rst) begin
      dv      <= '0;
      m_valid <= 1'b0;
      a_valid <= 1'b0;
      p_valid <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      dv        <= {dv[DIV_STEPS-2:0], !q_empty};
      m_valid   <= dv[DIV_STEPS-1];
      a_valid   <= m_valid;
      p_valid   <= a_valid;
      out_valid <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    logic [DW:0] st_s, st_l;
    if (adv) begin
      st_s  = div_step(DW'(q_item.ads), DW'(q_item.aspan));
      st_l  = div_step(q_item.ldist, q_item.limit);
      dk[0] <= q_item.kind;
      ds[0] <= DW'(q_item.aspan);
      dl[0] <= q_item.limit;
      rs[0] <= st_s[DW-1:0];
      rl[0] <= st_l[DW-1:0];
      qs[0] <= Q_BITS'(st_s[DW]);
      ql[0] <= Q_BITS'(st_l[DW]);
      for (int i = 1; i < DIV_STEPS; i++) begin
        st_s  = div_step(rs[i-1], ds[i-1]);
        st_l  = div_step(rl[i-1], dl[i-1]);
        dk[i] <= dk[i-1];
        ds[i] <= ds[i-1];
        dl[i] <= dl[i-1];
        rs[i] <= st_s[DW-1:0];
        rl[i] <= st_l[DW-1:0];
        qs[i] <= {qs[i-1][Q_BITS-2:0], st_s[DW]};
        ql[i] <= {ql[i-1][Q_BITS-2:0], st_l[DW]};
      end
      // squares
      m_kind <= dk[DIV_STEPS-1];
      sq_s   <= qs[DIV_STEPS-1] * qs[DIV_STEPS-1];
      sq_l   <= ql[DIV_STEPS-1] * ql[DIV_STEPS-1];
      // ellipse factor and its complement
      a_kind <= m_kind;
      a_in   <= !f_sum[2*Q_BITS];
      w      <= {1'b1, {(2*Q_BITS){1'b0}}} - f_sum;
      // scale peak
      p_kind <= a_kind;
      p_in   <= a_in;
      prod   <= peak_cost * w;
      // result word
      case (p_kind)
        KIND_PEAK: begin
          obs_cost <= peak_cost;
          cost_set <= 1'b1;
        end
        KIND_ELLIPSE: begin
          obs_cost <= p_in ? prod[2*Q_BITS+15:2*Q_BITS] : 16'd0;
          cost_set <= p_in;
        end
        default: begin
          obs_cost <= 16'd0;
          cost_set <= 1'b0;
        end
      endcase
    end
  end

endmodule

// ===== sv/behind_box_area_cost.sv =====
// Throughput: one word per cycle while unstalled; front and back stall
// independently via a 4-entry queue, the back via its output register.
// Reset (rst, synchronous, active high) clears valids, queue and
// registers them to half_width 243, soft_buffer 154, rect_range 1536,
// area_range 2560, peak_cost 20480.
module behind_box_area_cost import bbac_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  // config port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_W-1:0]    paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  // input words
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // box_min_s, box_max_s, box_min_l, box_max_l, front_s, front_l, rear_s, rear_l
  input  logic [8*POS_BITS-1:0] s_tdata,
  // result words
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [15:0]          m_tdata,   // obs_cost
  output logic                 m_tuser    // cost_set
);

  cfg_t cfg;
  logic wr_en;
  reg_idx_t idx;

  logic    q_full, q_empty, q_push, q_pop;
  q_item_t q_in, q_out;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.half_width  <= 11'd243;
      cfg.soft_buffer <= 11'd154;
      cfg.rect_range  <= 15'd1536;
      cfg.area_range  <= 15'd2560;
      cfg.peak_cost   <= 16'd20480;
    end else if (wr_en) begin
      case (idx)
        REG_HALF_WIDTH:  cfg.half_width  <= pwdata[10:0];
        REG_SOFT_BUFFER: cfg.soft_buffer <= pwdata[10:0];
        REG_RECT_RANGE:  cfg.rect_range  <= pwdata[14:0];
        REG_AREA_RANGE:  cfg.area_range  <= pwdata[14:0];
        REG_PEAK_COST:   cfg.peak_cost   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_HALF_WIDTH:  prdata = 32'(cfg.half_width);
      REG_SOFT_BUFFER: prdata = 32'(cfg.soft_buffer);
      REG_RECT_RANGE:  prdata = 32'(cfg.rect_range);
      REG_AREA_RANGE:  prdata = 32'(cfg.area_range);
      REG_PEAK_COST:   prdata = 32'(cfg.peak_cost);
      default:         prdata = 32'd0;
    endcase
  end

  // front: differences, point choice, region class
  bbac_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .box_min_s (s_tdata[0*POS_BITS +: POS_BITS]),
    .box_max_s (s_tdata[1*POS_BITS +: POS_BITS]),
    .box_min_l (s_tdata[2*POS_BITS +: POS_BITS]),
    .box_max_l (s_tdata[3*POS_BITS +: POS_BITS]),
    .front_s   (s_tdata[4*POS_BITS +: POS_BITS]),
    .front_l   (s_tdata[5*POS_BITS +: POS_BITS]),
    .rear_s    (s_tdata[6*POS_BITS +: POS_BITS]),
    .rear_l    (s_tdata[7*POS_BITS +: POS_BITS]),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (q_in)
  );

  bbac_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .pop_item  (q_out)
  );

  // back: two 16-step dividers, squares, scale by peak
  bbac_back u_back (
    .clk       (clk),
    .rst       (rst),
    .peak_cost (cfg.peak_cost),
    .q_empty   (q_empty),
    .q_item    (q_out),
    .q_pop     (q_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .obs_cost  (m_tdata),
    .cost_set  (m_tuser)
  );

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(q_push && q_full)) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(q_pop && q_empty)) else $error("queue underflow");
  a_zero_unset: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata == 16'd0)) else $error("cost without set");
  a_cost_cap: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata <= cfg.peak_cost)) else $error("cost above peak");
`endif

endmodule
